[src/dwf_pkg.sv]
// ----------------------------------------------------------------------------
// dwf_pkg
// Shared types and codes for the display I2C write framer.
// ----------------------------------------------------------------------------
`default_nettype none

package dwf_pkg;

  // bus symbol codes
  localparam logic [1:0] SYM_START = 2'd0;
  localparam logic [1:0] SYM_BIT   = 2'd1;
  localparam logic [1:0] SYM_ACK   = 2'd2;
  localparam logic [1:0] SYM_STOP  = 2'd3;

  // opcodes
  localparam logic [1:0] OP_CMD    = 2'd0;
  localparam logic [1:0] OP_DATA   = 2'd1;
  localparam logic [1:0] OP_BURST  = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // register indexes
  localparam logic [1:0] REG_DEV_ADDR = 2'd0;
  localparam logic [1:0] REG_CMD_CTRL = 2'd1;
  localparam logic [1:0] REG_DAT_CTRL = 2'd2;

  // register reset values
  localparam logic [7:0] DEV_ADDR_RST = 8'h78;
  localparam logic [7:0] CMD_CTRL_RST = 8'h00;
  localparam logic [7:0] DAT_CTRL_RST = 8'h40;

  // emitter phases
  localparam logic [2:0] PH_LEAD  = 3'd0;
  localparam logic [2:0] PH_START = 3'd1;
  localparam logic [2:0] PH_ADDR  = 3'd2;
  localparam logic [2:0] PH_CTRL  = 3'd3;
  localparam logic [2:0] PH_PAY   = 3'd4;
  localparam logic [2:0] PH_TRAIL = 3'd5;

  // bit slot of the acknowledge clock within a byte
  localparam logic [3:0] ACK_SLOT = 4'd8;

  typedef struct packed {
    logic       lead_stop;
    logic       header;
    logic       trail_stop;
    logic [7:0] addr;
    logic [7:0] ctrl;
    logic [7:0] payload;
  } plan_t;

endpackage

`default_nettype wire

[src/dwf_plan.sv]
// ----------------------------------------------------------------------------
// dwf_plan
// Decodes one input item against the burst state into a frame plan and
// holds it until the emitter takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module dwf_plan import dwf_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] opcode,
  input  wire logic [7:0] payload,
  input  wire logic       burst_first,
  input  wire logic       burst_last,
  input  wire logic [7:0] dev_addr,
  input  wire logic [7:0] cmd_ctrl,
  input  wire logic [7:0] dat_ctrl,
  output logic            plan_valid,
  output plan_t           plan,
  input  wire logic       plan_take
);

  logic  burst_open;
  logic  burst_open_next;
  logic  accept;
  plan_t plan_next;

  assign in_ready = !plan_valid || plan_take;
  assign accept   = in_valid && in_ready;

  always_comb begin
    plan_next.addr    = dev_addr;
    plan_next.payload = payload;
    plan_next.ctrl    = dat_ctrl;
    plan_next.lead_stop  = 1'b0;
    plan_next.header     = 1'b1;
    plan_next.trail_stop = 1'b1;
    burst_open_next = burst_open;
    unique case (opcode)
      OP_CMD, OP_DATA: begin
        plan_next.ctrl      = (opcode == OP_CMD) ? cmd_ctrl : dat_ctrl;
        plan_next.lead_stop = burst_open;
        burst_open_next     = 1'b0;
      end
      OP_BURST: begin
        plan_next.lead_stop  = burst_first && burst_open;
        plan_next.header     = burst_first || !burst_open;
        plan_next.trail_stop = burst_last;
        burst_open_next      = !burst_last;
      end
      default: begin
        burst_open_next = burst_open;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      plan_valid <= 1'b0;
      burst_open <= 1'b0;
    end else begin
      if (accept && opcode != OP_UNUSED) begin
        plan_valid <= 1'b1;
      end else if (plan_take) begin
        plan_valid <= 1'b0;
      end
      if (accept) begin
        burst_open <= burst_open_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      plan <= plan_next;
    end
  end

endmodule

`default_nettype wire

[src/dwf_emit.sv]
// ----------------------------------------------------------------------------
// dwf_emit
// Walks a plan into the output register, one symbol per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module dwf_emit import dwf_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       plan_valid,
  input  wire plan_t      plan,
  output logic            plan_take,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      symbol,
  output logic            bit_value,
  output logic            last_symbol
);

  plan_t      cur;
  logic       busy;
  logic [2:0] phase;
  logic [2:0] phase_next;
  logic [3:0] slot;
  logic       out_load;
  logic       emit;
  logic       cur_last;
  logic [1:0] sym_now;
  logic       bit_now;
  logic [7:0] byte_now;
  logic [2:0] first_phase;

  assign out_load  = !out_valid || out_ready;
  assign emit      = busy && out_load;
  assign cur_last  = (phase == PH_TRAIL) ||
                     (phase == PH_PAY && slot == ACK_SLOT && !cur.trail_stop);
  assign plan_take = plan_valid && (!busy || (emit && cur_last));

  assign first_phase = plan.lead_stop ? PH_LEAD : (plan.header ? PH_START : PH_PAY);

  always_comb begin
    unique case (phase)
      PH_ADDR: byte_now = cur.addr;
      PH_CTRL: byte_now = cur.ctrl;
      default: byte_now = cur.payload;
    endcase
  end

  always_comb begin
    sym_now = SYM_STOP;
    bit_now = 1'b0;
    unique case (phase)
      PH_START: sym_now = SYM_START;
      PH_ADDR, PH_CTRL, PH_PAY: begin
        if (slot == ACK_SLOT) begin
          sym_now = SYM_ACK;
        end else begin
          sym_now = SYM_BIT;
          bit_now = byte_now[3'd7 - slot[2:0]];
        end
      end
      default: sym_now = SYM_STOP;
    endcase
  end

  always_comb begin
    unique case (phase)
      PH_LEAD:  phase_next = cur.header ? PH_START : PH_PAY;
      PH_START: phase_next = PH_ADDR;
      PH_ADDR:  phase_next = PH_CTRL;
      PH_CTRL:  phase_next = PH_PAY;
      default:  phase_next = PH_TRAIL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
      phase     <= PH_LEAD;
      slot      <= '0;
    end else begin
      if (plan_take) begin
        busy  <= 1'b1;
        phase <= first_phase;
        slot  <= '0;
      end else if (emit) begin
        if (cur_last) begin
          busy <= 1'b0;
        end else if ((phase == PH_ADDR || phase == PH_CTRL || phase == PH_PAY) &&
                     slot != ACK_SLOT) begin
          slot <= slot + 4'd1;
        end else begin
          phase <= phase_next;
          slot  <= '0;
        end
      end
      if (out_load) begin
        out_valid <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (plan_take) begin
      cur <= plan;
    end
    if (out_load) begin
      symbol      <= sym_now;
      bit_value   <= bit_now;
      last_symbol <= cur_last;
    end
  end

endmodule

`default_nettype wire

[src/display_i2c_write_framer_top.sv]
// ----------------------------------------------------------------------------
// display_i2c_write_framer_top
// Write-only I2C framer: turns command, data and burst bytes into bus symbols.
// ----------------------------------------------------------------------------
// An item's first symbol passes the plan, emitter-state and output registers.
// Throughput: one symbol per cycle while out_ready allows; item length is set
//   by the number of symbols it causes (ack-clocked bytes plus start/stop).
// A second item is held in the plan register while the current one emits.
// Reset (synchronous): burst closed, outputs empty, registers to defaults.
`default_nettype none

module display_i2c_write_framer_top import dwf_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] opcode,
  input  wire logic [7:0] payload,
  input  wire logic       burst_first,
  input  wire logic       burst_last,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      symbol,
  output logic            bit_value,
  output logic            last_symbol,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  logic [7:0] dev_addr;
  logic [7:0] cmd_ctrl;
  logic [7:0] dat_ctrl;
  logic       plan_valid;
  plan_t      plan;
  logic       plan_take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dev_addr <= DEV_ADDR_RST;
      cmd_ctrl <= CMD_CTRL_RST;
      dat_ctrl <= DAT_CTRL_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DEV_ADDR: dev_addr <= cfg_data;
        REG_CMD_CTRL: cmd_ctrl <= cfg_data;
        REG_DAT_CTRL: dat_ctrl <= cfg_data;
        default: ;
      endcase
    end
  end

  dwf_plan u_plan (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .opcode      (opcode),
    .payload     (payload),
    .burst_first (burst_first),
    .burst_last  (burst_last),
    .dev_addr    (dev_addr),
    .cmd_ctrl    (cmd_ctrl),
    .dat_ctrl    (dat_ctrl),
    .plan_valid  (plan_valid),
    .plan        (plan),
    .plan_take   (plan_take)
  );

  dwf_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .plan_valid  (plan_valid),
    .plan        (plan),
    .plan_take   (plan_take),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .symbol      (symbol),
    .bit_value   (bit_value),
    .last_symbol (last_symbol)
  );

endmodule

`default_nettype wire

[src/dwf_checker.sv]
// ----------------------------------------------------------------------------
// dwf_checker
// Port-level checks on the framer's result stream.
// ----------------------------------------------------------------------------
`default_nettype none

module dwf_checker import dwf_pkg::*; (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] symbol,
  input wire logic       bit_value,
  input wire logic       last_symbol
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(symbol) &&
      $stable(bit_value) && $stable(last_symbol))
    else $error("result changed while stalled");

  a_bit_only_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && symbol != SYM_BIT |-> !bit_value)
    else $error("bit_value set on a non-data symbol");

  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_symbol |-> symbol == SYM_STOP || symbol == SYM_ACK)
    else $error("item ends on start or data bit");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind display_i2c_write_framer_top dwf_checker u_dwf_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .symbol      (symbol),
  .bit_value   (bit_value),
  .last_symbol (last_symbol)
);

`default_nettype wire
